FILE: sv/rcp_pkg.sv
// rcp_pkg: shared types, constants and table functions for the rotated circle evaluator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package rcp_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;
    // datapath width: radius plus CORDIC growth plus margin
    localparam int VW            = 36;
    // residual angle width, signed with headroom
    localparam int AW            = ANGLE_BITS + 2;
    localparam int SW            = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam logic [30:0] GAIN_Q30 = 31'd652032874;

    // register indexes on the config port
    typedef enum logic [2:0] {
        REG_RADIUS = 3'd0,
        REG_POS_X  = 3'd1,
        REG_POS_Y  = 3'd2,
        REG_POS_Z  = 3'd3,
        REG_ROT_X  = 3'd4,
        REG_ROT_Y  = 3'd5,
        REG_ROT_Z  = 3'd6
    } t_reg_idx;

    localparam logic CMD_DERIV = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] angle;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } t_result;

    // one item travelling down the chain; a,b is the pair being rotated, c rides along
    typedef struct packed {
        logic                 valid;
        logic                 deriv;
        logic signed [VW-1:0] a;
        logic signed [VW-1:0] b;
        logic signed [VW-1:0] c;
        logic signed [AW-1:0] z;
    } t_beat;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn32(input int i);
        logic [31:0] tab [32];
        tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
                32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
                32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
                32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
        return tab[i];
    endfunction

    // per-stage angle step, rounded half-up to ANGLE_BITS
    function automatic logic signed [AW-1:0] atan_step(input int i);
        logic [63:0] v;
        v = ({32'd0, atan_turn32(i)} + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
        return $signed(v[AW-1:0]);
    endfunction

    // 16 bit turn fraction to ANGLE_BITS
    function automatic logic [ANGLE_BITS-1:0] to_angle_bits(input logic [15:0] a16);
        logic [63:0] v;
        if (ANGLE_BITS >= 16) begin
            v = {48'd0, a16} << (ANGLE_BITS - 16);
        end else begin
            v = {48'd0, a16} >> (16 - ANGLE_BITS);
        end
        return v[ANGLE_BITS-1:0];
    endfunction

endpackage

FILE: sv/rcp_gain_cell.sv
// rcp_gain_cell: gain compensation of the pair, quarter-turn pre-rotation and angle split.
// Depends on rcp_pkg.
`timescale 1ns / 1ps
module rcp_gain_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rcp_pkg::t_beat i_beat,
    input  logic [15:0]   i_angle,
    output rcp_pkg::t_beat o_beat
);

    localparam int PW = rcp_pkg::VW + 31;
    localparam int AB = rcp_pkg::ANGLE_BITS;

    logic signed [PW-1:0] w_pa, w_pb;
    logic signed [rcp_pkg::VW-1:0] w_ga, w_gb;
    logic [AB-1:0] w_s;
    logic [1:0]    w_q;
    rcp_pkg::t_beat r_beat, n_beat;

    // multiply by K with half-up rounding, floor shift
    always_comb begin
        w_pa = (PW'(i_beat.a) * $signed({1'b0, rcp_pkg::GAIN_Q30}))
               + (PW'(1) <<< 29);
        w_pb = (PW'(i_beat.b) * $signed({1'b0, rcp_pkg::GAIN_Q30}))
               + (PW'(1) <<< 29);
        w_ga = w_pa[rcp_pkg::VW+29:30];
        w_gb = w_pb[rcp_pkg::VW+29:30];
    end

    // quadrant and residual
    always_comb begin
        w_s = rcp_pkg::to_angle_bits(i_angle) + (AB'(1) << (AB - 3));
        w_q = w_s[AB-1:AB-2];
        n_beat       = i_beat;
        n_beat.z     = rcp_pkg::AW'($signed({1'b0, w_s[AB-3:0]}))
                       - (rcp_pkg::AW'(1) <<< (AB - 3));
        case (w_q)
            2'd1: begin
                n_beat.a = -w_gb;
                n_beat.b = w_ga;
            end
            2'd2: begin
                n_beat.a = -w_ga;
                n_beat.b = -w_gb;
            end
            2'd3: begin
                n_beat.a = w_gb;
                n_beat.b = -w_ga;
            end
            default: begin
                n_beat.a = w_ga;
                n_beat.b = w_gb;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

FILE: sv/rcp_cordic_cell.sv
// rcp_cordic_cell: one registered CORDIC rotation-mode micro-rotation.
// Depends on rcp_pkg.
`timescale 1ns / 1ps
module rcp_cordic_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rcp_pkg::SW-1:0]       i_shift,
    input  logic signed [rcp_pkg::AW-1:0] i_step,
    input  rcp_pkg::t_beat               i_beat,
    output rcp_pkg::t_beat               o_beat
);

    logic signed [rcp_pkg::VW-1:0] w_da, w_db;
    rcp_pkg::t_beat r_beat, n_beat;

    // arithmetic shifts floor, as the spec asks
    always_comb begin
        w_da   = i_beat.b >>> i_shift;
        w_db   = i_beat.a >>> i_shift;
        n_beat = i_beat;
        if (!i_beat.z[rcp_pkg::AW-1]) begin
            n_beat.a = i_beat.a - w_da;
            n_beat.b = i_beat.b + w_db;
            n_beat.z = i_beat.z - i_step;
        end else begin
            n_beat.a = i_beat.a + w_da;
            n_beat.b = i_beat.b - w_db;
            n_beat.z = i_beat.z + i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

FILE: sv/rcp_rotator.sv
// rcp_rotator: gain cell followed by a chain of CORDIC cells, one full plane rotation.
// Depends on rcp_pkg, rcp_gain_cell, rcp_cordic_cell.
`timescale 1ns / 1ps
module rcp_rotator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rcp_pkg::t_beat i_beat,
    input  logic [15:0]    i_angle,
    output rcp_pkg::t_beat o_beat
);

    rcp_pkg::t_beat w_chain [rcp_pkg::CORDIC_STAGES+1];

    rcp_gain_cell u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (i_beat),
        .i_angle (i_angle),
        .o_beat  (w_chain[0])
    );

    // row of micro-rotation cells
    for (genvar g = 0; g < rcp_pkg::CORDIC_STAGES; g++) begin : g_cell
        rcp_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (rcp_pkg::SW'(g)),
            .i_step  (rcp_pkg::atan_step(g)),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    assign o_beat = w_chain[rcp_pkg::CORDIC_STAGES];

endmodule

FILE: sv/rotated_circle_point_eval_unit.sv
// Rotated circle point evaluator: config registers, input stage, three rotators, output clamp.
// Depends on rcp_pkg and rcp_rotator.
// Throughput: one item per cycle; busy is never raised, the pipeline has no stall.
// Each CORDIC cell is one register stage; the gain multiplier sets one stage per rotation.
// Reset (synchronous, active low) clears the config registers to 0 and empties the pipeline.
`timescale 1ns / 1ps
module rotated_circle_point_eval_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  rcp_pkg::t_cmd    i_cmd,
    output logic             o_valid,
    output rcp_pkg::t_result o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int VW = rcp_pkg::VW;

    logic [30:0] r_radius;
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic [15:0] r_rot_x, r_rot_y, r_rot_z;
    rcp_pkg::t_reg_idx w_idx;
    logic w_wr;

    rcp_pkg::t_beat r_in, w_r1, w_r2, w_r3, w_i2, w_i3;
    logic [15:0] r_ang1;
    logic signed [VW:0] w_sx, w_sy, w_sz;
    logic [2:0] w_sat;
    rcp_pkg::t_result n_result, r_result;
    logic r_valid;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_idx  = rcp_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_pos_z  <= '0;
            r_rot_x  <= '0;
            r_rot_y  <= '0;
            r_rot_z  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                rcp_pkg::REG_RADIUS: r_radius <= pwdata[30:0];
                rcp_pkg::REG_POS_X:  r_pos_x  <= pwdata;
                rcp_pkg::REG_POS_Y:  r_pos_y  <= pwdata;
                rcp_pkg::REG_POS_Z:  r_pos_z  <= pwdata;
                rcp_pkg::REG_ROT_X:  r_rot_x  <= pwdata[15:0];
                rcp_pkg::REG_ROT_Y:  r_rot_y  <= pwdata[15:0];
                rcp_pkg::REG_ROT_Z:  r_rot_z  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (w_idx)
            rcp_pkg::REG_RADIUS: prdata = {1'b0, r_radius};
            rcp_pkg::REG_POS_X:  prdata = r_pos_x;
            rcp_pkg::REG_POS_Y:  prdata = r_pos_y;
            rcp_pkg::REG_POS_Z:  prdata = r_pos_z;
            rcp_pkg::REG_ROT_X:  prdata = {16'd0, r_rot_x};
            rcp_pkg::REG_ROT_Y:  prdata = {16'd0, r_rot_y};
            rcp_pkg::REG_ROT_Z:  prdata = {16'd0, r_rot_z};
            default:             prdata = '0;
        endcase
    end

    // input stage: circle vector and merged in-plane angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in.valid <= start;
            r_in.deriv <= (i_cmd.command == rcp_pkg::CMD_DERIV);
            r_in.a     <= VW'($signed({1'b0, r_radius}));
            r_in.b     <= '0;
            r_in.c     <= '0;
            r_in.z     <= '0;
            r_ang1     <= i_cmd.angle + r_rot_z
                          + ((i_cmd.command == rcp_pkg::CMD_DERIV) ? 16'h4000 : 16'h0000);
        end
    end

    // about Z (merged with the curve angle): pair (x,y)
    rcp_rotator u_rot1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_beat (r_in), .i_angle (r_ang1), .o_beat (w_r1)
    );

    // about Y: pair (z,x), y rides along
    always_comb begin
        w_i2   = w_r1;
        w_i2.a = w_r1.c;
        w_i2.b = w_r1.a;
        w_i2.c = w_r1.b;
    end

    rcp_rotator u_rot2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_beat (w_i2), .i_angle (r_rot_y), .o_beat (w_r2)
    );

    // about X: pair (y,z), x rides along
    always_comb begin
        w_i3   = w_r2;
        w_i3.a = w_r2.c;
        w_i3.b = w_r2.a;
        w_i3.c = w_r2.b;
    end

    rcp_rotator u_rot3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_beat (w_i3), .i_angle (r_rot_x), .o_beat (w_r3)
    );

    // position offset and clamp; x=c, y=a, z=b here
    always_comb begin
        w_sx = (VW+1)'(w_r3.c);
        w_sy = (VW+1)'(w_r3.a);
        w_sz = (VW+1)'(w_r3.b);
        if (!w_r3.deriv) begin
            w_sx = w_sx + (VW+1)'(r_pos_x);
            w_sy = w_sy + (VW+1)'(r_pos_y);
            w_sz = w_sz + (VW+1)'(r_pos_z);
        end
        w_sat[0] = (w_sx > (VW+1)'(64'sd2147483647)) || (w_sx < (VW+1)'(-64'sd2147483648));
        w_sat[1] = (w_sy > (VW+1)'(64'sd2147483647)) || (w_sy < (VW+1)'(-64'sd2147483648));
        w_sat[2] = (w_sz > (VW+1)'(64'sd2147483647)) || (w_sz < (VW+1)'(-64'sd2147483648));
        n_result.out_x = w_sat[0] ? {w_sx[VW], {31{~w_sx[VW]}}} : w_sx[31:0];
        n_result.out_y = w_sat[1] ? {w_sy[VW], {31{~w_sy[VW]}}} : w_sy[31:0];
        n_result.out_z = w_sat[2] ? {w_sz[VW], {31{~w_sz[VW]}}} : w_sz[31:0];
        n_result.saturated = |w_sat;
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_r3.valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: test/rcp_checker.sv
// rcp_checker: watches the command and result channels of the rotated circle evaluator,
// predicts each result from its own copy of the configuration and compares. Depends on rcp_pkg.
`timescale 1ns / 1ps
module rcp_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  rcp_pkg::t_cmd    i_cmd,
    input  logic             o_valid,
    input  rcp_pkg::t_result o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    output int               o_fail_count,
    output int               o_pending
);

    localparam longint K_GAIN = 64'sd652032874;

    // shadow of the configuration registers
    logic [30:0] cfg_radius;
    longint      cfg_pos_x, cfg_pos_y, cfg_pos_z;
    logic [15:0] cfg_rot_x, cfg_rot_y, cfg_rot_z;

    rcp_pkg::t_result points_due[$];

    assign o_pending = points_due.size();

    // multiply by inverse CORDIC gain, half-up rounding (>>> floors)
    function automatic longint scale_by_gain(longint v);
        return (v * K_GAIN + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // quadrant fold then CORDIC rotation of pair (a,b) by a turn fraction
    function automatic void cordic_turn(ref longint a, ref longint b, input logic [15:0] ang);
        logic [15:0] s;
        logic [1:0]  quad;
        longint      z, da, db, tmp, step;
        s = ang + 16'h2000;
        quad = s[15:14];
        z = longint'(s[13:0]) - 64'sd8192;
        case (quad)
            2'd1: begin tmp = a; a = -b; b = tmp; end
            2'd2: begin a = -a; b = -b; end
            2'd3: begin tmp = a; a = b; b = -tmp; end
            default: ;
        endcase
        for (int i = 0; i < rcp_pkg::CORDIC_STAGES; i++) begin
            step = longint'((64'(rcp_pkg::atan_turn32(i)) + 64'h8000) >> 16);
            da = b >>> i;
            db = a >>> i;
            if (z >= 0) begin
                a -= da; b += db; z -= step;
            end else begin
                a += da; b -= db; z += step;
            end
        end
    endfunction

    function automatic logic [31:0] clamp_q16(longint v, ref logic flag);
        if (v > 64'sd2147483647) begin flag = 1'b1; return 32'h7FFF_FFFF; end
        if (v < -64'sd2147483648) begin flag = 1'b1; return 32'h8000_0000; end
        return v[31:0];
    endfunction

    function automatic rcp_pkg::t_result eval_circle_point(rcp_pkg::t_cmd c);
        rcp_pkg::t_result r;
        logic        dv, sat;
        logic [15:0] t_ang;
        longint      vx, vy, vz;
        dv = (c.command == rcp_pkg::CMD_DERIV);
        t_ang = c.angle + cfg_rot_z + (dv ? 16'h4000 : 16'h0000);
        sat = 1'b0;
        vx = scale_by_gain(longint'(cfg_radius));
        vy = 0;
        vz = 0;
        cordic_turn(vx, vy, t_ang);
        vz = scale_by_gain(vz);
        vx = scale_by_gain(vx);
        cordic_turn(vz, vx, cfg_rot_y);
        vy = scale_by_gain(vy);
        vz = scale_by_gain(vz);
        cordic_turn(vy, vz, cfg_rot_x);
        if (!dv) begin
            vx += cfg_pos_x; vy += cfg_pos_y; vz += cfg_pos_z;
        end
        r.out_x = clamp_q16(vx, sat);
        r.out_y = clamp_q16(vy, sat);
        r.out_z = clamp_q16(vz, sat);
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        rcp_pkg::t_result want;
        if (!i_rst_n) begin
            cfg_radius <= '0;
            cfg_pos_x <= 0; cfg_pos_y <= 0; cfg_pos_z <= 0;
            cfg_rot_x <= '0; cfg_rot_y <= '0; cfg_rot_z <= '0;
            points_due.delete();
            o_fail_count <= 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    rcp_pkg::REG_RADIUS: cfg_radius <= pwdata[30:0];
                    rcp_pkg::REG_POS_X:  cfg_pos_x <= longint'(signed'(pwdata));
                    rcp_pkg::REG_POS_Y:  cfg_pos_y <= longint'(signed'(pwdata));
                    rcp_pkg::REG_POS_Z:  cfg_pos_z <= longint'(signed'(pwdata));
                    rcp_pkg::REG_ROT_X:  cfg_rot_x <= pwdata[15:0];
                    rcp_pkg::REG_ROT_Y:  cfg_rot_y <= pwdata[15:0];
                    rcp_pkg::REG_ROT_Z:  cfg_rot_z <= pwdata[15:0];
                    default: ;
                endcase
            end
            // result beat
            if (o_valid) begin
                if (points_due.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time,
                             o_result.out_x, o_result.out_y, o_result.out_z,
                             o_result.saturated);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = points_due.pop_front();
                    if (want !== o_result) begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h sat=%b",
                                 $time, want.out_x, want.out_y, want.out_z, want.saturated);
                        $display("%0t:          actual   x=%h y=%h z=%h sat=%b",
                                 $time, o_result.out_x, o_result.out_y, o_result.out_z,
                                 o_result.saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // command beat: config is stable while items run
            if (start && !busy) points_due.push_back(eval_circle_point(i_cmd));
        end
    end
endmodule

FILE: test/tb_top.sv
// tb_top: stimulus and verdict for rotated_circle_point_eval_unit.
// Depends on rcp_pkg, the block and rcp_checker.
`timescale 1ns / 1ps
module tb_top;

    localparam int LATENCY   = 2 + 3 * (rcp_pkg::CORDIC_STAGES + 1);
    localparam int IDLE_STOP = 2000;

    logic             i_clk, i_rst_n, start, busy, o_valid;
    rcp_pkg::t_cmd    i_cmd;
    rcp_pkg::t_result o_result;
    logic             psel, penable, pwrite, pready;
    logic [4:0]       paddr;
    logic [31:0]      pwdata, prdata;
    int               fail_count, pending, quiet_cycles;

    rotated_circle_point_eval_unit dut (.*);

    rcp_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd, .o_valid, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_STOP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // setup then access; psel stays high across back-to-back writes
    task automatic reg_write(rcp_pkg::t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // one command beat, with random gap drawn per item (runs of no gap too)
    task automatic send_cmd(logic cmd, logic [15:0] ang, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= '{command: cmd, angle: ang};
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic load_setting(logic [31:0] rad, logic [31:0] px, logic [31:0] py,
                                logic [31:0] pz, logic [15:0] rx, logic [15:0] ry,
                                logic [15:0] rz);
        reg_write(rcp_pkg::REG_RADIUS, rad);
        reg_write(rcp_pkg::REG_POS_X, px);
        reg_write(rcp_pkg::REG_POS_Y, py);
        reg_write(rcp_pkg::REG_POS_Z, pz);
        reg_write(rcp_pkg::REG_ROT_X, {16'h0, rx});
        reg_write(rcp_pkg::REG_ROT_Y, {16'h0, ry});
        reg_write(rcp_pkg::REG_ROT_Z, {16'h0, rz});
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    initial begin
        logic [15:0] edge_angles [8];
        bit          gappy;
        i_rst_n = 1'b0; start = 1'b0; i_cmd = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: angle extremes and both commands, plain then rotated frame
        edge_angles = '{16'h0000, 16'hFFFF, 16'h2000, 16'h4000, 16'h8000, 16'hC000,
                        16'h1FFF, 16'h6000};
        load_setting(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0, 16'h0, 16'h0, 16'h0);
        foreach (edge_angles[k]) send_cmd(1'b0, edge_angles[k], 1'b0);
        send_cmd(1'b1, 16'h0000, 1'b0);
        send_cmd(1'b1, 16'hFFFF, 1'b0);
        drain();
        // largest radius with extreme offsets: clamp both ways, derivative clamps too
        load_setting(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     16'hFFFF, 16'h8000, 16'hFFFF);
        foreach (edge_angles[k]) send_cmd(k[0], edge_angles[k], 1'b0);
        drain();
        load_setting(32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000, 16'h4000, 16'h2000, 16'h1234);
        send_cmd(1'b0, 16'h5555, 1'b0);
        send_cmd(1'b1, 16'hAAAA, 1'b0);
        drain();

        // random phases with fresh settings
        for (int ph = 0; ph < 10; ph++) begin
            load_setting($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000),
                         $urandom, $urandom, $urandom,
                         16'($urandom), 16'($urandom), 16'($urandom));
            gappy = (ph % 3 != 0);
            for (int n = 0; n < 63; n++) begin
                send_cmd(1'($urandom_range(0, 1)), 16'($urandom), gappy);
            end
            drain();
        end
        // idle-state register is also reset-zero settled; end of run
        load_setting(32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
        drain();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
